[hdl/gated_pulse_count_reporter_top_macros.svh]
// assertion macros for the gated pulse count reporter
// expects clk_i and rst_ni in the scope of each use
`ifndef GATED_PULSE_COUNT_REPORTER_TOP_MACROS_SVH
`define GATED_PULSE_COUNT_REPORTER_TOP_MACROS_SVH

// condition that must hold in the same cycle
`define GPCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after the antecedent
`define GPCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/gpcr_pkg.sv]
// shared types and constants of the gated pulse count reporter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gpcr_pkg;

  // field widths
  localparam int unsigned ColorW = 3;
  localparam int unsigned CharW  = 8;
  localparam int unsigned CfgW   = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned TickW  = 8;
  localparam int unsigned PulseW = 10;

  // default number of report digits
  localparam int unsigned DigitsDef = 3;

  // counter limits and register resets
  localparam logic [PulseW-1:0] PulseMax     = 10'd999;
  localparam logic [TickW-1:0]  TickMax      = 8'd255;
  localparam logic [CfgW-1:0]   ReportTickRst = 8'd8;
  localparam logic [CfgW-1:0]   EndTickRst    = 8'd16;

  // report characters
  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharCr   = 8'd13;
  localparam logic [CharW-1:0] CharLf   = 8'd10;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgReportTick = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgEndTick    = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_MEAS = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  typedef enum logic [ColorW-1:0] {
    COLOR_OFF    = 3'd0,
    COLOR_RED    = 3'd1,
    COLOR_YELLOW = 3'd2,
    COLOR_WHITE  = 3'd3,
    COLOR_VIOLET = 3'd4
  } color_e;

endpackage

`default_nettype wire

[hdl/gpcr_in_if.sv]
// sample channel: one word is one sample of the three pin levels
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface gpcr_in_if;
  logic valid;
  logic ready;
  logic gate_pressed;
  logic pulse_edge;
  logic period_tick;

  modport source (output valid, output gate_pressed, output pulse_edge,
                  output period_tick, input ready);
  modport sink   (input valid, input gate_pressed, input pulse_edge,
                  input period_tick, output ready);
endinterface

`default_nettype wire

[hdl/gpcr_out_if.sv]
// result channel: led, valve and report character words
// depends on gpcr_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface gpcr_out_if;
  import gpcr_pkg::*;
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] led_color;
  logic              valve_open;
  logic              char_valid;
  logic [CharW-1:0]  tx_char;
  logic              last;

  modport source (output valid, output led_color, output valve_open, output char_valid,
                  output tx_char, output last, input ready);
  modport sink   (input valid, input led_color, input valve_open, input char_valid,
                  input tx_char, input last, output ready);
endinterface

`default_nettype wire

[hdl/gated_pulse_count_reporter_top.sv]
// gated pulse count reporter: controller state, result register and report serializer
// depends on gpcr_pkg, gpcr_in_if, gpcr_out_if and the assertion macro header
//
// usage
//   in_if carries one sample word per handshake: gate level, pulse edge, period tick.
//   out_if carries result words: led color, valve drive, and an optional report
//   character with a last flag marking the final word caused by a sample.
//   cfg_we_i / cfg_idx_i / cfg_wdata_i write report_tick (index 0) and end_tick
//   (index 1); write only while no result is pending.
// timing
//   a sample is taken and the controller updated in the cycle it is accepted; its
//   first result word is valid on the next cycle.
//   ordinary samples give a word each, taken every cycle while out_if.ready is high.
//   a report gives DIGITS+2 words (digits, CR, LF) drained one per cycle by the
//   serializer while out_if.ready is high; no new sample is taken until LF leaves.
//   in_if.ready stays high while the result register is empty or its last word
//   is leaving, so a new sample overlaps the final word of the one before.
// reset and stall
//   reset clears the controller (idle, counts zero, timer stopped, led off, valve
//   closed), restores the register defaults and empties the result register.
//   when out_if.ready is low the current word holds and in_if.ready falls.
`timescale 1ns / 1ps
`default_nettype none
`include "gated_pulse_count_reporter_top_macros.svh"

module gated_pulse_count_reporter_top #(
  parameter int unsigned DIGITS = gpcr_pkg::DigitsDef
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [gpcr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire  [gpcr_pkg::CfgW-1:0]        cfg_wdata_i,
  gpcr_in_if.sink                          in_if,
  gpcr_out_if.source                       out_if
);
  import gpcr_pkg::*;

  localparam int unsigned IdxW = $clog2(DIGITS + 2);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DIGITS + 1);
  localparam logic [IdxW-1:0] CrIdx   = IdxW'(DIGITS);
  localparam logic [IdxW-1:0] TopPos  = IdxW'(DIGITS - 1);

  // configuration registers
  logic [CfgW-1:0] report_tick_q, end_tick_q;

  // controller state
  phase_e           phase_q, phase_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [PulseW-1:0] pulse_q, pulse_d;
  logic             timer_q, timer_d;
  color_e           color_q, color_d;
  logic             valve_q, valve_d;
  logic             report_d;
  logic [TickW-1:0] tick_inc;
  logic [PulseW-1:0] pulse_inc;

  // result register and serializer
  logic              out_valid_q;
  color_e            res_color_q;
  logic              res_valve_q;
  logic              res_report_q;
  logic [IdxW-1:0]   idx_q;
  logic [PulseW-1:0] res_val_q;

  logic in_fire, out_fire, out_last, in_ready;

  // digit extraction
  logic [17:0]       prod10;
  logic [15:0]       prod100;
  logic [6:0]        q10;
  logic [3:0]        q100;
  logic [PulseW-1:0] tens10;
  logic [6:0]        tens100;
  logic [PulseW-1:0] rem10;
  logic [6:0]        rem100;
  logic [3:0]        d0, d1, d2, digit;
  logic [IdxW-1:0]   pos;
  logic [CharW-1:0]  char_sel;

  // handshake
  assign out_last = !res_report_q || (idx_q == LastIdx);
  assign in_ready = !out_valid_q || (out_if.ready && out_last);
  assign in_if.ready = in_ready;
  assign in_fire  = in_if.valid && in_ready;
  assign out_fire = out_valid_q && out_if.ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_tick_q <= ReportTickRst;
      end_tick_q    <= EndTickRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgReportTick: report_tick_q <= cfg_wdata_i;
        CfgEndTick:    end_tick_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // saturating counter increments
  always_comb begin
    tick_inc = tick_q;
    if (in_if.period_tick && timer_q && (tick_q != TickMax)) begin
      tick_inc = tick_q + TickW'(1);
    end
    pulse_inc = pulse_q;
    if (in_if.gate_pressed && in_if.pulse_edge && (pulse_q < PulseMax)) begin
      pulse_inc = pulse_q + PulseW'(1);
    end
  end

  // controller next state
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_inc;
    pulse_d  = pulse_inc;
    timer_d  = timer_q;
    color_d  = color_q;
    valve_d  = valve_q;
    report_d = 1'b0;
    if (!in_if.gate_pressed) begin
      color_d = COLOR_RED;
      valve_d = 1'b0;
      tick_d  = '0;
      pulse_d = '0;
      phase_d = PH_IDLE;
    end else if (phase_q == PH_IDLE) begin
      color_d = COLOR_YELLOW;
      valve_d = 1'b1;
      tick_d  = '0;
      pulse_d = '0;
      timer_d = 1'b1;
      phase_d = PH_MEAS;
    end else if ((phase_q == PH_MEAS) && (tick_inc == report_tick_q)) begin
      color_d  = COLOR_WHITE;
      phase_d  = PH_DONE;
      report_d = 1'b1;
    end else if (tick_inc >= end_tick_q) begin
      timer_d = 1'b0;
      color_d = COLOR_VIOLET;
      phase_d = PH_IDLE;
    end
  end

  // controller state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      pulse_q <= '0;
      timer_q <= 1'b0;
      color_q <= COLOR_OFF;
      valve_q <= 1'b0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      pulse_q <= pulse_d;
      timer_q <= timer_d;
      color_q <= color_d;
      valve_q <= valve_d;
    end
  end

  // result valid and serializer index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (out_fire) begin
      if (out_last) begin
        out_valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_color_q  <= color_d;
      res_valve_q  <= valve_d;
      res_report_q <= report_d;
      res_val_q    <= pulse_d;
    end
  end

  // decimal digits by reciprocal multiply, exact for counts up to 999
  always_comb begin
    prod10  = 18'({8'b0, res_val_q} * 18'd205);
    prod100 = 16'({6'b0, res_val_q} * 16'd41);
    q10     = prod10[17:11];
    q100    = prod100[15:12];
    tens10  = {q10, 3'b0} + {2'b0, q10, 1'b0};
    tens100 = {q100, 3'b0} + {2'b0, q100, 1'b0};
    rem10   = res_val_q - tens10;
    rem100  = q10 - tens100;
    d0      = rem10[3:0];
    d1      = rem100[3:0];
    d2      = q100;
  end

  // character select: digits most significant first, then CR, then LF
  always_comb begin
    pos = TopPos - idx_q;
    if (pos == IdxW'(0)) begin
      digit = d0;
    end else if (pos == IdxW'(1)) begin
      digit = d1;
    end else if (pos == IdxW'(2)) begin
      digit = d2;
    end else begin
      digit = '0;
    end
    if (idx_q == LastIdx) begin
      char_sel = CharLf;
    end else if (idx_q == CrIdx) begin
      char_sel = CharCr;
    end else begin
      char_sel = CharZero + {4'b0, digit};
    end
  end

  // result port
  assign out_if.valid      = out_valid_q;
  assign out_if.led_color  = res_color_q;
  assign out_if.valve_open = res_valve_q;
  assign out_if.char_valid = res_report_q;
  assign out_if.tx_char    = res_report_q ? char_sel : '0;
  assign out_if.last       = out_last;

  // assertions
  `GPCR_ASSERT_NEXT(a_result_after_accept, in_fire, out_valid_q,
                    "accepted sample left no result word")
  `GPCR_ASSERT_NOW(a_report_blocks_input, out_valid_q && res_report_q && (idx_q != LastIdx),
                   !in_ready, "sample accepted while report characters are pending")
  `GPCR_ASSERT_NOW(a_meas_timer_runs, phase_q == PH_MEAS, timer_q,
                   "measuring with the timer stopped")
  `GPCR_ASSERT_NOW(a_reported_valve_open, phase_q == PH_DONE, valve_q,
                   "reported phase with the valve closed")
  `GPCR_ASSERT_NOW(a_pulse_saturates, 1'b1, pulse_q <= PulseMax,
                   "pulse count beyond its limit")

endmodule

`default_nettype wire

[test/tb_top.sv]
// self-checking bench for the gated pulse count reporter: directed, saturation and random tests
// predicts every result word in-bench and compares in order; needs gpcr_pkg and both channel ifs
`timescale 1ns / 1ps

module tb_top;
  import gpcr_pkg::*;

  localparam int unsigned StallLimit = 4000;

  // one expected result word
  typedef struct packed {
    color_e           color;
    logic             valve;
    logic             cv;
    logic [CharW-1:0] ch;
    logic             last;
  } result_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0] cfg_wdata;

  gpcr_in_if  in_if ();
  gpcr_out_if out_if ();

  gated_pulse_count_reporter_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  // predicted controller state and register copies
  phase_e            ctl_phase;
  logic [TickW-1:0]  ctl_ticks;
  logic [PulseW-1:0] ctl_pulses;
  logic              ctl_timer_on;
  color_e            ctl_color;
  logic              ctl_valve;
  logic [CfgW-1:0]   report_at;
  logic [CfgW-1:0]   end_at;

  result_word_t expected_words[$];
  int unsigned  error_count;
  int unsigned  samples_sent;
  int unsigned  quiet_cycles;
  bit           sender_idles;
  bit           receiver_stalls;
  int           hold_left;

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tb_top: mismatch on %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // advance the controller by one sample and queue the words it causes
  function automatic void predict_sample(input logic gate, input logic pedge, input logic tick);
    result_word_t w;
    int unsigned  v;
    logic [CharW-1:0] digit [DigitsDef];
    bit sends_report;
    sends_report = 1'b0;
    if (tick && ctl_timer_on && ctl_ticks < TickMax) ctl_ticks = ctl_ticks + 1'b1;
    if (gate && pedge && ctl_pulses < PulseMax) ctl_pulses = ctl_pulses + 1'b1;
    if (!gate) begin
      // release aborts; the timer keeps its state
      ctl_color = COLOR_RED;
      ctl_valve = 1'b0;
      ctl_ticks = '0;
      ctl_pulses = '0;
      ctl_phase = PH_IDLE;
    end else if (ctl_phase == PH_IDLE) begin
      ctl_color = COLOR_YELLOW;
      ctl_valve = 1'b1;
      ctl_ticks = '0;
      ctl_pulses = '0;
      ctl_timer_on = 1'b1;
      ctl_phase = PH_MEAS;
    end else if (ctl_phase == PH_MEAS && ctl_ticks == report_at) begin
      ctl_color = COLOR_WHITE;
      ctl_phase = PH_DONE;
      sends_report = 1'b1;
    end else if (ctl_ticks >= end_at) begin
      ctl_timer_on = 1'b0;
      ctl_color = COLOR_VIOLET;
      ctl_phase = PH_IDLE;
    end
    w.color = ctl_color;
    w.valve = ctl_valve;
    if (!sends_report) begin
      w.cv = 1'b0;
      w.ch = '0;
      w.last = 1'b1;
      expected_words.push_back(w);
    end else begin
      // zero-padded decimal, most significant digit first, then cr and lf
      v = {22'b0, ctl_pulses};
      for (int i = DigitsDef - 1; i >= 0; i--) begin
        digit[i] = CharZero + CharW'(v % 10);
        v = v / 10;
      end
      w.cv = 1'b1;
      w.last = 1'b0;
      for (int i = 0; i < DigitsDef; i++) begin
        w.ch = digit[i];
        expected_words.push_back(w);
      end
      w.ch = CharCr;
      expected_words.push_back(w);
      w.ch = CharLf;
      w.last = 1'b1;
      expected_words.push_back(w);
    end
  endfunction

  // monitor: check result words, predict accepted samples, track writes, watchdog
  always @(posedge clk) begin
    result_word_t w;
    if (rst_n) begin
      quiet_cycles++;
      if (out_if.valid && out_if.ready) begin
        quiet_cycles = 0;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result word", 1, 0);
        end else begin
          w = expected_words.pop_front();
          if (out_if.led_color !== w.color) report_mismatch("led_color", out_if.led_color, w.color);
          if (out_if.valve_open !== w.valve) report_mismatch("valve_open", out_if.valve_open, w.valve);
          if (out_if.char_valid !== w.cv) report_mismatch("char_valid", out_if.char_valid, w.cv);
          if (out_if.tx_char !== w.ch) report_mismatch("tx_char", out_if.tx_char, w.ch);
          if (out_if.last !== w.last) report_mismatch("last", out_if.last, w.last);
        end
      end
      if (in_if.valid && in_if.ready) begin
        quiet_cycles = 0;
        predict_sample(in_if.gate_pressed, in_if.pulse_edge, in_if.period_tick);
      end
      if (cfg_we) begin
        if (cfg_idx == CfgReportTick) report_at = cfg_wdata;
        else if (cfg_idx == CfgEndTick) end_at = cfg_wdata;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // receiver: random stalls plus a counted hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (receiver_stalls && $urandom_range(99) < 13) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // offer one sample word and wait until it is taken
  task automatic send_sample(input logic gate, input logic pedge, input logic tick);
    if (sender_idles && $urandom_range(99) < 13) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.gate_pressed <= gate;
    in_if.pulse_edge   <= pedge;
    in_if.period_tick  <= tick;
    do @(posedge clk); while (!in_if.ready);
    samples_sent++;
  endtask

  // stop offering and wait until every expected word has been received
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // register write while the block is idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_ticks(input logic [CfgW-1:0] rpt, input logic [CfgW-1:0] stop);
    write_reg(CfgReportTick, rpt);
    write_reg(CfgEndTick, stop);
  endtask

  // one held-gate measurement with random edges and ticks
  task automatic run_measurement(input int len, input int tick_pct, input int edge_pct,
                                 input bit release_after);
    for (int i = 0; i < len; i++)
      send_sample(1'b1, $urandom_range(99) < edge_pct, $urandom_range(99) < tick_pct);
    if (release_after) send_sample(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // reset register values: report at tick 8, stop at 16
  task automatic test_reset_defaults();
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0);
    for (int i = 0; i < 9; i++) send_sample(1'b1, i[0], 1'b1);
    send_sample(1'b0, 1'b1, 1'b1);
  endtask

  // short walk through every branch of the controller
  task automatic test_directed();
    set_ticks(8'd2, 8'd4);
    send_sample(1'b1, 1'b1, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b1);
    send_sample(1'b1, 1'b1, 1'b1);
    send_sample(1'b1, 1'b0, 1'b1);
    send_sample(1'b1, 1'b0, 1'b1);
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b0, 1'b1, 1'b1);
    send_sample(1'b0, 1'b0, 1'b1);
  endtask

  // register extremes, including end before report
  task automatic test_reg_extremes();
    set_ticks(8'd0, 8'd0);
    run_measurement(6, 50, 50, 1'b1);
    set_ticks(8'd255, 8'd0);
    run_measurement(6, 50, 50, 1'b1);
    set_ticks(8'd0, 8'd255);
    run_measurement(6, 50, 50, 1'b1);
    set_ticks(8'd1, 8'd1);
    run_measurement(6, 100, 50, 1'b0);
  endtask

  // tick counter pinned at its top while reported
  task automatic test_tick_saturation();
    set_ticks(8'd255, 8'd255);
    run_measurement(258, 100, 50, 1'b1);
  endtask

  // receiver holds off while samples keep coming, so the input stalls
  task automatic test_backpressure();
    set_ticks(8'd1, 8'd3);
    sender_idles = 1'b0;
    hold_left = 64;
    run_measurement(24, 80, 50, 1'b1);
    drain_results();
    sender_idles = 1'b1;
  endtask

  // long stretch with no idling on either side
  task automatic test_no_idle();
    set_ticks(8'd2, 8'd5);
    sender_idles = 1'b0;
    receiver_stalls = 1'b0;
    for (int i = 0; i < 4; i++) run_measurement(9, 70, 50, 1'b1);
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // random sessions: mostly held-gate measurements, some noise and reconfiguration
  task automatic test_random();
    int unsigned stop_at;
    logic [CfgW-1:0] rpt;
    logic [CfgW-1:0] stop;
    stop_at = samples_sent + 8;
    while (samples_sent < stop_at) begin
      if ($urandom_range(99) < 25) begin
        rpt  = ($urandom_range(9) == 0) ? CfgW'($urandom_range(255)) : CfgW'($urandom_range(10));
        stop = ($urandom_range(9) == 0) ? CfgW'($urandom_range(255)) : CfgW'($urandom_range(12));
        set_ticks(rpt, stop);
      end
      if ($urandom_range(99) < 85) begin
        run_measurement($urandom_range(16, 1), $urandom_range(100, 30), 50,
                        1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(4, 1))
          send_sample(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.gate_pressed = 1'b0;
    in_if.pulse_edge = 1'b0;
    in_if.period_tick = 1'b0;
    ctl_phase = PH_IDLE;
    ctl_ticks = '0;
    ctl_pulses = '0;
    ctl_timer_on = 1'b0;
    ctl_color = COLOR_OFF;
    ctl_valve = 1'b0;
    report_at = ReportTickRst;
    end_at = EndTickRst;
    error_count = 0;
    samples_sent = 0;
    quiet_cycles = 0;
    hold_left = 0;
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed();
    test_reg_extremes();
    test_backpressure();
    test_no_idle();
    test_tick_saturation();
    test_random();

    drain_results();
    repeat (5) @(posedge clk);
    if (expected_words.size() != 0) begin
      report_mismatch("pending result words", expected_words.size(), 0);
    end
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/gpcr_pkg.sv
hdl/gpcr_in_if.sv
hdl/gpcr_out_if.sv
hdl/gated_pulse_count_reporter_top.sv
test/tb_top.sv
